// ===== rtl/smm_pkg.sv =====
// shared types and constants of the square matrix multiplier
`default_nettype none

package smm_pkg;

    localparam int MAX_DIM_DEF = 4;
    localparam int INDEX_REACH = 4;
    localparam int IDX_W       = 2;
    localparam int DIM_W       = 3;
    localparam int ELEM_W      = 32;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int FRAC_W      = 16;

    localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;

    localparam logic signed [ELEM_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ELEM_W-1:0] Q_MIN = 32'sh8000_0000;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_MULT  = 1'b1;
    localparam logic MAT_A     = 1'b0;
    localparam logic MAT_B     = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic                     which_matrix;
        logic [IDX_W-1:0]         elem_row;
        logic [IDX_W-1:0]         elem_col;
        logic signed [ELEM_W-1:0] elem_value;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [ELEM_W-1:0] out_value;
        logic                     out_saturated;
        logic                     out_last;
    } out_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_HOLD,
        CTRL_ISSUE,
        CTRL_WAIT
    } ctrl_state_t;

    // tag travelling with each product term down the pipeline
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             first;
        logic             last_k;
        logic             last_elem;
    } tag_t;

    typedef struct packed {
        logic             mem_we;
        logic             issue;
        logic [IDX_W-1:0] k;
        tag_t             tag;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
        logic loaded;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/smm_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module smm_ram #(
    parameter int WIDTH = smm_pkg::ELEM_W,
    parameter int DEPTH = smm_pkg::MAX_DIM_DEF * smm_pkg::MAX_DIM_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/smm_datapath.sv =====
// operand stores, multiply-accumulate pipeline and result register
`default_nettype none

module smm_datapath #(
    parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire smm_pkg::cmd_t  cmd,
    input  wire smm_pkg::in_t   in_data,
    output smm_pkg::status_t    sts,
    output logic                out_valid,
    input  wire logic           out_ready,
    output smm_pkg::out_t       out_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SHW   = smm_pkg::ACC_W - smm_pkg::FRAC_W;

    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic          we_a;
    logic          we_b;
    logic [smm_pkg::ELEM_W-1:0] rdata_a;
    logic [smm_pkg::ELEM_W-1:0] rdata_b;

    assign waddr   = AW'(int'(in_data.elem_row) * MAX_DIM + int'(in_data.elem_col));
    assign raddr_a = AW'(int'(cmd.tag.row) * MAX_DIM + int'(cmd.k));
    assign raddr_b = AW'(int'(cmd.k) * MAX_DIM + int'(cmd.tag.col));
    assign we_a    = cmd.mem_we && (in_data.which_matrix == smm_pkg::MAT_A);
    assign we_b    = cmd.mem_we && (in_data.which_matrix == smm_pkg::MAT_B);

    smm_ram #(
        .WIDTH (smm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (in_data.elem_value),
        .re    (cmd.issue),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    smm_ram #(
        .WIDTH (smm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (in_data.elem_value),
        .re    (cmd.issue),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    // pipeline control
    logic          valid_s1_reg;
    logic          valid_s2_reg;
    logic          done_reg;
    smm_pkg::tag_t tag_s1_reg;
    smm_pkg::tag_t tag_s2_reg;
    smm_pkg::tag_t tag_s3_reg;

    logic signed [smm_pkg::PROD_W-1:0] prod_reg;
    logic signed [smm_pkg::PROD_W-1:0] prod_next;
    logic signed [smm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [smm_pkg::ACC_W-1:0]  acc_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    smm_pkg::out_t out_data_reg;
    smm_pkg::out_t out_data_next;

    logic signed [smm_pkg::ACC_W-1:0] shifted;
    logic                             pos_ovf;
    logic                             neg_ovf;

    assign prod_next = smm_pkg::PROD_W'($signed(rdata_a)) *
                       smm_pkg::PROD_W'($signed(rdata_b));

    assign acc_next = tag_s2_reg.first ? smm_pkg::ACC_W'(prod_reg)
                                       : acc_reg + smm_pkg::ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg  <= 1'b0;
            valid_s2_reg  <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg  <= cmd.issue;
            valid_s2_reg  <= valid_s1_reg;
            done_reg      <= valid_s2_reg && tag_s2_reg.last_k;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_s1_reg <= cmd.tag;
        tag_s2_reg <= tag_s1_reg;
        prod_reg   <= prod_next;
        if (valid_s2_reg)
        begin
            acc_reg    <= acc_next;
            tag_s3_reg <= tag_s2_reg;
        end
        out_data_reg <= out_data_next;
    end

    // floor shift back to q16.16, then clip to 32 bits
    assign shifted = acc_reg >>> smm_pkg::FRAC_W;
    assign pos_ovf = !shifted[smm_pkg::ACC_W-1] && (|shifted[SHW-1:smm_pkg::ELEM_W-1]);
    assign neg_ovf = shifted[smm_pkg::ACC_W-1] && !(&shifted[SHW-1:smm_pkg::ELEM_W-1]);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (done_reg)
        begin
            out_valid_next              = 1'b1;
            out_data_next.out_row       = tag_s3_reg.row;
            out_data_next.out_col       = tag_s3_reg.col;
            out_data_next.out_last      = tag_s3_reg.last_elem;
            out_data_next.out_saturated = pos_ovf || neg_ovf;
            priority if (pos_ovf)
            begin
                out_data_next.out_value = smm_pkg::Q_MAX;
            end
            else if (neg_ovf)
            begin
                out_data_next.out_value = smm_pkg::Q_MIN;
            end
            else
            begin
                out_data_next.out_value = shifted[smm_pkg::ELEM_W-1:0];
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign sts.out_busy = out_valid_reg;
    assign sts.loaded   = done_reg;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/smm_ctrl.sv =====
// sequencer walking row, column and inner index of the product
`default_nettype none

module smm_ctrl #(
    parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [smm_pkg::DIM_W-1:0]    cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire smm_pkg::in_t                 in_data,
    input  wire smm_pkg::status_t             sts,
    output smm_pkg::cmd_t                     cmd
);

    localparam int CAP = (MAX_DIM < smm_pkg::INDEX_REACH) ? MAX_DIM : smm_pkg::INDEX_REACH;

    smm_pkg::ctrl_state_t state_reg;
    smm_pkg::ctrl_state_t state_next;

    logic [smm_pkg::DIM_W-1:0] dim_in_use_reg;
    logic [smm_pkg::IDX_W-1:0] dim_m1_reg;
    logic [smm_pkg::IDX_W-1:0] dim_m1_next;
    logic [smm_pkg::IDX_W-1:0] i_reg;
    logic [smm_pkg::IDX_W-1:0] i_next;
    logic [smm_pkg::IDX_W-1:0] j_reg;
    logic [smm_pkg::IDX_W-1:0] j_next;
    logic [smm_pkg::IDX_W-1:0] k_reg;
    logic [smm_pkg::IDX_W-1:0] k_next;

    logic [smm_pkg::DIM_W-1:0] dim_clamped;
    logic                      mult_acc;
    logic                      in_range;
    logic                      last_k;
    logic                      last_elem;

    always_comb
    begin
        priority if (dim_in_use_reg == '0)
        begin
            dim_clamped = smm_pkg::DIM_W'(1);
        end
        else if (int'(dim_in_use_reg) > CAP)
        begin
            dim_clamped = smm_pkg::DIM_W'(CAP);
        end
        else
        begin
            dim_clamped = dim_in_use_reg;
        end
    end

    assign mult_acc  = in_valid && in_ready && (in_data.req_type == smm_pkg::REQ_MULT);
    assign in_range  = (int'(in_data.elem_row) < MAX_DIM) && (int'(in_data.elem_col) < MAX_DIM);
    assign last_k    = (k_reg == dim_m1_reg);
    assign last_elem = (i_reg == dim_m1_reg) && (j_reg == dim_m1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= smm_pkg::CTRL_IDLE;
            dim_in_use_reg <= smm_pkg::DIM_RESET;
            dim_m1_reg     <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            dim_m1_reg <= dim_m1_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            if (cfg_wr_en)
            begin
                dim_in_use_reg <= cfg_wr_data;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smm_pkg::CTRL_IDLE:
            begin
                if (mult_acc)
                begin
                    state_next = smm_pkg::CTRL_HOLD;
                end
            end
            smm_pkg::CTRL_HOLD:
            begin
                if (!sts.out_busy)
                begin
                    state_next = smm_pkg::CTRL_ISSUE;
                end
            end
            smm_pkg::CTRL_ISSUE:
            begin
                if (last_k)
                begin
                    state_next = smm_pkg::CTRL_WAIT;
                end
            end
            smm_pkg::CTRL_WAIT:
            begin
                if (sts.loaded)
                begin
                    state_next = last_elem ? smm_pkg::CTRL_IDLE : smm_pkg::CTRL_HOLD;
                end
            end
            default:
            begin
                state_next = smm_pkg::CTRL_IDLE;
            end
        endcase
    end

    // index counters
    always_comb
    begin
        dim_m1_next = dim_m1_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        if (mult_acc)
        begin
            dim_m1_next = smm_pkg::IDX_W'(dim_clamped - smm_pkg::DIM_W'(1));
            i_next      = '0;
            j_next      = '0;
            k_next      = '0;
        end
        else if (state_reg == smm_pkg::CTRL_ISSUE)
        begin
            k_next = last_k ? '0 : k_reg + 1'b1;
        end
        else if ((state_reg == smm_pkg::CTRL_WAIT) && sts.loaded && !last_elem)
        begin
            if (j_reg == dim_m1_reg)
            begin
                j_next = '0;
                i_next = i_reg + 1'b1;
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end
    end

    // outputs
    always_comb
    begin
        in_ready = (state_reg == smm_pkg::CTRL_IDLE);
        cmd.mem_we = in_valid && in_ready && (in_data.req_type == smm_pkg::REQ_WRITE) &&
                     in_range;
        cmd.issue         = (state_reg == smm_pkg::CTRL_ISSUE);
        cmd.k             = k_reg;
        cmd.tag.row       = i_reg;
        cmd.tag.col       = j_reg;
        cmd.tag.first     = (k_reg == '0);
        cmd.tag.last_k    = last_k;
        cmd.tag.last_elem = last_elem;
    end

endmodule

`default_nettype wire

// ===== rtl/square_matrix_multiply.sv =====
// top level of the square q16.16 matrix multiplier
//
//  channel   direction  handshake              beat
//  cfg       in         cfg_wr_en              cfg_wr_data -> dim_in_use
//  in        in         in_valid / in_ready    in_data   (smm_pkg::in_t)
//  out       out        out_valid / out_ready  out_data  (smm_pkg::out_t)
//
// an element write beat leaves in_ready high
// a multiply beat holds in_ready low until the last product element is loaded into the output register:
// per element the inner index walks through one shared mac (ram read, multiply, accumulate),
// then the pipeline drains, the sum is clipped, and the beat is handed over before the next element
// out_ready low stalls the sequencer before the next element starts
// rst_n clears control state only; the operand stores are not cleared
`default_nettype none

module square_matrix_multiply #(
    parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration
    input  wire logic                      cfg_wr_en,
    input  wire logic [smm_pkg::DIM_W-1:0] cfg_wr_data,
    // request beats
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire smm_pkg::in_t              in_data,
    // product beats
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output smm_pkg::out_t                  out_data
);

    // commands from the sequencer and status back from the datapath
    smm_pkg::cmd_t    cmd;
    smm_pkg::status_t sts;

    smm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .sts         (sts),
        .cmd         (cmd)
    );

    // operand rams, mac pipeline and output register
    smm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/smm_checker.sv =====
// port-level checks of the matrix multiplier, bound to the top level
`default_nettype none

module smm_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire smm_pkg::in_t  in_data,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire smm_pkg::out_t out_data
);

    // a stalled product beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("product beat changed while stalled");

    // a multiply beat closes the input side
    a_mult_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.req_type == smm_pkg::REQ_MULT) |=> !in_ready)
        else $error("input accepted right after a multiply");

    // an element write keeps the input side open
    a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.req_type == smm_pkg::REQ_WRITE) |=> in_ready)
        else $error("element write stalled the input");

    // the final element sits on the diagonal
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_last |-> out_data.out_row == out_data.out_col)
        else $error("last flag off the diagonal");

endmodule

bind square_matrix_multiply smm_checker u_smm_checker (.*);

`default_nettype wire
